[rtl/skt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, widths and codes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_CHARS = 8;

    localparam int KEY_W   = 64;
    localparam int GEN_W   = 8;
    localparam int SCORE_W = 24;
    localparam int NREF_W  = 32;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 3;
    localparam int ENT_W   = 6;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 136;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_CHARS);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [GEN_W-1:0]          gender;
        logic signed [SCORE_W-1:0] score;
        logic [NREF_W-1:0]         name_ref;
    } t_rec;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_rec              data;
    } t_mem_wr;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

endpackage

[rtl/skt_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_mem
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_mem (
    input  logic             i_clk,
    input  skt_pkg::t_mem_wr i_wr,
    input  skt_pkg::t_mem_rd i_rd,
    output skt_pkg::t_rec    o_rd_data
);
    import skt_pkg::*;

    t_rec r_mem [CAPACITY];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.re) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/skt_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cmp
// Shared key comparator: stored key against search key, unsigned.
// ----------------------------------------------------------------------------
module skt_cmp (
    input  logic [skt_pkg::KEY_W-1:0] i_entry_key,
    input  logic [skt_pkg::KEY_W-1:0] i_search_key,
    output skt_pkg::t_cmp             o_cmp
);
    import skt_pkg::*;

    always_comb begin
        o_cmp.eq = (i_entry_key == i_search_key);
        o_cmp.lt = (i_entry_key < i_search_key);
    end

endmodule

[rtl/sorted_key_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of records kept in ascending key order with insert, delete and list.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time and drops o_s_tready until all
// its result beats are loaded into the output register. Work runs through a
// record store with one write and one read port and one shared key
// comparator: an insert scans from the first record to find its place,
// moves the records from there up one slot, top first, then writes the new
// record; a delete scans to find the record, then moves the later records
// down one slot to close the gap; a list reads each record in turn and
// emits it once the output register is free.
// Nothing needs clearing after reset: the table starts empty.
// ----------------------------------------------------------------------------
module sorted_key_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // key[63:0], gender[71:64], score[95:72], name_ref[127:96]
    input  logic [skt_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // command[1:0]
    input  logic [skt_pkg::CMD_W-1:0]         i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // rec_key[63:0], rec_gender[71:64], rec_score[95:72],
    // rec_name_ref[127:96], entries[133:128], zero[135:134]
    output logic [skt_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // status[2:0]
    output logic [skt_pkg::ST_W-1:0]          o_m_tuser,
    output logic                              o_m_tlast
);
    import skt_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_CMP  = 4'd2;
    localparam logic [3:0] S_SHIFT_RD  = 4'd3;
    localparam logic [3:0] S_SHIFT_WR  = 4'd4;
    localparam logic [3:0] S_WRITE     = 4'd5;
    localparam logic [3:0] S_EMIT      = 4'd6;
    localparam logic [3:0] S_LIST_RD   = 4'd7;
    localparam logic [3:0] S_LIST_EMIT = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic             r_ovalid, n_ovalid;

    logic [CMD_W-1:0] r_cmd, n_cmd;
    t_rec             r_new, n_new;
    t_rec             r_res, n_res;
    logic [ST_W-1:0]  r_res_st, n_res_st;
    t_rec             r_odata, n_odata;
    logic [ST_W-1:0]  r_ost, n_ost;
    logic [ENT_W-1:0] r_oent, n_oent;
    logic             r_olast, n_olast;

    t_mem_wr          mem_wr;
    t_mem_rd          mem_rd;
    t_rec             rd_data;
    t_cmp             cmp;
    logic             out_free;
    logic             is_full;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;

    skt_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd      (mem_rd),
        .o_rd_data (rd_data)
    );

    skt_cmp u_cmp (
        .i_entry_key  (rd_data.key),
        .i_search_key (r_new.key),
        .o_cmp        (cmp)
    );

    assign out_free = !r_ovalid || i_m_tready;
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign idx_inc  = CNT_W'(r_idx + 1'b1);
    assign idx_dec  = CNT_W'(r_idx - 1'b1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_cmd    = r_cmd;
        n_new    = r_new;
        n_res    = r_res;
        n_res_st = r_res_st;
        n_odata  = r_odata;
        n_ost    = r_ost;
        n_oent   = r_oent;
        n_olast  = r_olast;
        mem_wr   = '0;
        mem_rd   = '0;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd           = i_s_tuser;
                    n_new.key       = i_s_tdata[63:0] & KEY_MASK;
                    n_new.gender    = i_s_tdata[71:64];
                    n_new.score     = i_s_tdata[95:72];
                    n_new.name_ref  = i_s_tdata[127:96];
                    n_idx           = '0;
                    case (i_s_tuser)
                        CMD_INSERT: begin
                            n_state = S_SCAN_RD;
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_res_st = ST_EMPTY;
                                n_res    = '0;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        CMD_LIST: begin
                            if (r_count == '0) begin
                                n_res_st = ST_EMPTY;
                                n_res    = '0;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_LIST_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    if (r_cmd == CMD_INSERT) begin
                        if (is_full) begin
                            n_res_st = ST_FULL;
                            n_res    = r_new;
                            n_state  = S_EMIT;
                        end else begin
                            n_pos   = r_count;
                            n_idx   = r_count;
                            n_state = S_SHIFT_RD;
                        end
                    end else begin
                        n_res_st = ST_NOTFOUND;
                        n_res    = '0;
                        n_state  = S_EMIT;
                    end
                end else begin
                    mem_rd.re   = 1'b1;
                    mem_rd.addr = r_idx[ADDR_W-1:0];
                    n_state     = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (cmp.lt) begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN_RD;
                end else if (r_cmd == CMD_INSERT) begin
                    if (cmp.eq) begin
                        n_res_st = ST_DUP;
                        n_res    = r_new;
                        n_state  = S_EMIT;
                    end else if (is_full) begin
                        n_res_st = ST_FULL;
                        n_res    = r_new;
                        n_state  = S_EMIT;
                    end else begin
                        n_pos   = r_idx;
                        n_idx   = r_count;
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    if (cmp.eq) begin
                        n_res   = rd_data;
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_res_st = ST_NOTFOUND;
                        n_res    = '0;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_SHIFT_RD: begin
                if (r_cmd == CMD_INSERT) begin
                    if (r_idx == r_pos) begin
                        n_state = S_WRITE;
                    end else begin
                        mem_rd.re   = 1'b1;
                        mem_rd.addr = idx_dec[ADDR_W-1:0];
                        n_state     = S_SHIFT_WR;
                    end
                end else begin
                    if (idx_inc >= r_count) begin
                        n_count  = CNT_W'(r_count - 1'b1);
                        n_res_st = ST_OK;
                        n_state  = S_EMIT;
                    end else begin
                        mem_rd.re   = 1'b1;
                        mem_rd.addr = idx_inc[ADDR_W-1:0];
                        n_state     = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR: begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = r_idx[ADDR_W-1:0];
                mem_wr.data = rd_data;
                n_idx       = (r_cmd == CMD_INSERT) ? idx_dec : idx_inc;
                n_state     = S_SHIFT_RD;
            end
            S_WRITE: begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = r_pos[ADDR_W-1:0];
                mem_wr.data = r_new;
                n_count     = CNT_W'(r_count + 1'b1);
                n_res_st    = ST_OK;
                n_res       = r_new;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_ost    = r_res_st;
                    n_oent   = ENT_W'(r_count);
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_LIST_RD: begin
                mem_rd.re   = 1'b1;
                mem_rd.addr = r_idx[ADDR_W-1:0];
                n_state     = S_LIST_EMIT;
            end
            S_LIST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = rd_data;
                    n_ost    = ST_OK;
                    n_oent   = ENT_W'(r_count);
                    n_olast  = (idx_inc == r_count);
                    n_idx    = idx_inc;
                    n_state  = (idx_inc == r_count) ? S_IDLE : S_LIST_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_new    <= n_new;
        r_res    <= n_res;
        r_res_st <= n_res_st;
        r_odata  <= n_odata;
        r_ost    <= n_ost;
        r_oent   <= n_oent;
        r_olast  <= n_olast;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_oent, r_odata.name_ref, r_odata.score,
                         r_odata.gender, r_odata.key};
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("record count beyond capacity");

    a_write_only_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.we |-> (r_state == S_SHIFT_WR || r_state == S_WRITE))
        else $error("record store written outside a move or insert step");

    a_count_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        (r_count == CNT_W'($past(r_count) + 1'b1) ||
         CNT_W'(r_count + 1'b1) == $past(r_count)))
        else $error("record count changed by more than one");

    a_list_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST_EMIT || r_state == S_LIST_RD) |-> (r_idx < r_count))
        else $error("list walked past the last record");

endmodule

[tb/sorted_key_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table. It streams insert, delete,
// list and unused-code beats into the block and keeps its own sorted copy of
// the table to predict every result beat. Each result beat is checked field
// by field. The run starts with a short directed part, then fills the table
// past full and applies random mixes under changing idle patterns.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int POOL_N = 48;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        t_rec             rec;
    } t_table_op;

    typedef struct {
        logic [ST_W-1:0]  status;
        t_rec             rec;
        logic [ENT_W-1:0] entries;
        logic             last;
    } t_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // key[63:0], gender[71:64], score[95:72], name_ref[127:96]
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    // command[1:0]
    logic [CMD_W-1:0]     i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // rec_key[63:0], rec_gender[71:64], rec_score[95:72],
    // rec_name_ref[127:96], entries[133:128], zero[135:134]
    logic [M_TDATA_W-1:0] o_m_tdata;
    // status[2:0]
    logic [ST_W-1:0]      o_m_tuser;
    logic                 o_m_tlast;

    t_table_op   op_backlog[$];
    t_reply      table_replies[$];
    t_rec        held_recs[CAPACITY];
    int          held = 0;
    int          ops_queued = 0;
    int          beats_offered = 0;
    int          beats_accepted = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          failed = 1'b0;
    logic [63:0] key_pool[POOL_N];
    t_table_op   next_op;
    t_reply      want;

    sorted_key_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int slot_of(input logic [KEY_W-1:0] key);
        for (int i = 0; i < held; i++)
            if (held_recs[i].key == key)
                return i;
        return -1;
    endfunction

    task automatic post_reply(input logic [ST_W-1:0] status, input t_rec rec,
                              input logic last);
        t_reply r;
        r.status  = status;
        r.rec     = rec;
        r.entries = held[ENT_W-1:0];
        r.last    = last;
        table_replies.push_back(r);
    endtask

    task automatic apply_table_op(input logic [CMD_W-1:0] cmd,
                                  input logic [S_TDATA_W-1:0] data);
        t_rec arg;
        t_rec gone;
        int   pos;
        arg.key      = data[63:0] & KEY_MASK;
        arg.gender   = data[71:64];
        arg.score    = data[95:72];
        arg.name_ref = data[127:96];
        case (cmd)
            CMD_INSERT: begin
                if (slot_of(arg.key) >= 0) begin
                    post_reply(ST_DUP, arg, 1'b1);
                end else if (held >= CAPACITY) begin
                    post_reply(ST_FULL, arg, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < held && held_recs[pos].key < arg.key)
                        pos++;
                    for (int i = held; i > pos; i--)
                        held_recs[i] = held_recs[i-1];
                    held_recs[pos] = arg;
                    held++;
                    post_reply(ST_OK, arg, 1'b1);
                end
            end
            CMD_DELETE: begin
                pos = slot_of(arg.key);
                if (held == 0) begin
                    post_reply(ST_EMPTY, '0, 1'b1);
                end else if (pos < 0) begin
                    post_reply(ST_NOTFOUND, '0, 1'b1);
                end else begin
                    gone = held_recs[pos];
                    for (int i = pos; i + 1 < held; i++)
                        held_recs[i] = held_recs[i+1];
                    held--;
                    post_reply(ST_OK, gone, 1'b1);
                end
            end
            CMD_LIST: begin
                if (held == 0)
                    post_reply(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < held; i++)
                        post_reply(ST_OK, held_recs[i], i == held - 1);
            end
            default: ;
        endcase
    endtask

    // driver: new beat only once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (beats_offered == beats_accepted) begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_op = op_backlog.pop_front();
                    i_s_tdata  <= {next_op.rec.name_ref, next_op.rec.score,
                                   next_op.rec.gender, next_op.rec.key};
                    i_s_tuser  <= next_op.cmd;
                    i_s_tvalid <= 1'b1;
                    beats_offered++;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted command beats, check result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                apply_table_op(i_s_tuser, i_s_tdata);
                beats_accepted++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (table_replies.size() == 0) begin
                    $error("unexpected result beat: status %0d key %h",
                           o_m_tuser, o_m_tdata[63:0]);
                    failed = 1'b1;
                end else begin
                    want = table_replies.pop_front();
                    if (o_m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_m_tuser);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[63:0] !== want.rec.key) begin
                        $error("rec_key: expected %h, actual %h",
                               want.rec.key, o_m_tdata[63:0]);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[71:64] !== want.rec.gender) begin
                        $error("rec_gender: expected %h, actual %h",
                               want.rec.gender, o_m_tdata[71:64]);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[95:72] !== want.rec.score) begin
                        $error("rec_score: expected %0d, actual %0d",
                               want.rec.score, $signed(o_m_tdata[95:72]));
                        failed = 1'b1;
                    end
                    if (o_m_tdata[127:96] !== want.rec.name_ref) begin
                        $error("rec_name_ref: expected %h, actual %h",
                               want.rec.name_ref, o_m_tdata[127:96]);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[133:128] !== want.entries) begin
                        $error("entries: expected %0d, actual %0d",
                               want.entries, o_m_tdata[133:128]);
                        failed = 1'b1;
                    end
                    if (o_m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, o_m_tlast);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    function automatic logic [63:0] pack_name(input string s);
        logic [63:0] k;
        k = '0;
        for (int i = 0; i < 8; i++)
            k = {k[55:0], (i < s.len()) ? s[i] : 8'h00};
        return k;
    endfunction

    task automatic queue_op(input logic [CMD_W-1:0] cmd, input logic [63:0] key,
                            input logic [7:0] gender, input logic [23:0] score,
                            input logic [31:0] name_ref);
        t_table_op op;
        op.cmd          = cmd;
        op.rec.key      = key;
        op.rec.gender   = gender;
        op.rec.score    = score;
        op.rec.name_ref = name_ref;
        op_backlog.push_back(op);
        ops_queued++;
    endtask

    task automatic queue_random(input logic [CMD_W-1:0] cmd, input logic [63:0] key);
        queue_op(cmd, key, 8'($urandom), 24'($urandom), 32'($urandom));
    endtask

    // insert-heavy and delete-heavy stretches alternate
    task automatic queue_mixed(input int n);
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [63:0]      key;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(99);
            if (r < 6)
                cmd = CMD_LIST;
            else if (r < 8)
                cmd = CMD_UNUSED;
            else if (r < (((j / 30) % 2 == 0) ? 75 : 30))
                cmd = CMD_INSERT;
            else
                cmd = CMD_DELETE;
            if ($urandom_range(9) == 0)
                key = {$urandom, $urandom};
            else
                key = key_pool[$urandom_range(POOL_N - 1)];
            queue_random(cmd, key);
        end
    endtask

    // insert every pool key once in shuffled order: runs into full
    task automatic queue_fill();
        int order[POOL_N];
        int k;
        int t;
        for (int i = 0; i < POOL_N; i++)
            order[i] = i;
        for (int i = POOL_N - 1; i > 0; i--) begin
            k = $urandom_range(i);
            t = order[i];
            order[i] = order[k];
            order[k] = t;
        end
        for (int i = 0; i < POOL_N; i++)
            queue_random(CMD_INSERT, key_pool[order[i]]);
    endtask

    task automatic drain();
        while (beats_accepted != ops_queued || table_replies.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int len;
        logic [63:0] k;
        key_pool[0] = '1;
        key_pool[1] = '0;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int i = 4; i < 16; i++) begin
            len = $urandom_range(8, 1);
            k = '0;
            for (int c = 0; c < 8; c++)
                k = {k[55:0], (c < len) ? 8'($urandom_range(90, 65)) : 8'h00};
            key_pool[i] = k;
        end
        for (int i = 16; i < POOL_N; i++)
            key_pool[i] = {$urandom, $urandom};

        send_idle_pct = 29;
        recv_idle_pct = 78;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_op(CMD_DELETE, pack_name("ZED"), 8'h4D, 24'd100, 32'd1);
        queue_op(CMD_LIST, '0, 8'h00, 24'd0, 32'd0);
        queue_op(CMD_UNUSED, '1, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        queue_op(CMD_INSERT, '1, 8'hFF, 24'h7FFFFF, 32'hFFFF_FFFF);
        queue_op(CMD_INSERT, '0, 8'h00, 24'h800000, 32'h0000_0000);
        queue_op(CMD_INSERT, pack_name("ALICE"), 8'h46, 24'hFFFFFF, 32'h1234_5678);
        queue_op(CMD_INSERT, pack_name("BOB"), 8'h4D, 24'd9050, 32'h8000_0001);
        queue_op(CMD_INSERT, pack_name("ALICE"), 8'h4D, 24'd1, 32'hDEAD_BEEF);
        queue_op(CMD_INSERT, pack_name("ALICEB"), 8'h46, 24'h000001, 32'h0000_0002);
        queue_op(CMD_LIST, '1, 8'hFF, 24'h7FFFFF, 32'hFFFF_FFFF);
        queue_op(CMD_DELETE, pack_name("ZED"), 8'h00, 24'd0, 32'd0);
        queue_op(CMD_DELETE, pack_name("ALICE"), 8'hAA, 24'h555555, 32'h5555_AAAA);
        queue_op(CMD_DELETE, '0, 8'h00, 24'd0, 32'd0);
        queue_op(CMD_DELETE, '1, 8'h00, 24'd0, 32'd0);
        queue_op(CMD_LIST, '0, 8'h00, 24'd0, 32'd0);
        queue_op(CMD_UNUSED, pack_name("BOB"), 8'h55, 24'hAAAAAA, 32'hAAAA_5555);
        queue_op(CMD_DELETE, pack_name("BOB"), 8'h00, 24'd0, 32'd0);
        queue_op(CMD_DELETE, pack_name("ALICEB"), 8'h00, 24'd0, 32'd0);
        queue_op(CMD_DELETE, pack_name("ALICEB"), 8'h00, 24'd0, 32'd0);
        queue_op(CMD_LIST, '0, 8'h00, 24'd0, 32'd0);
        queue_fill();
        queue_op(CMD_LIST, '0, 8'h00, 24'd0, 32'd0);
        queue_mixed(62);
        drain();

        send_idle_pct = 78;
        recv_idle_pct = 29;
        queue_mixed(110);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_mixed(110);
        drain();

        repeat (200) @(posedge i_clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
